@@ hdl/mdn_pkg.sv @@
// ----------------------------------------------------------------------------
// mdn_pkg
// Shared constants and types for the most-divisors lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package mdn_pkg;

  // Default number of table entries (numbers 0 .. TABLE_SIZE_DEF-1)
  localparam int unsigned TABLE_SIZE_DEF = 65536;

  // Field widths
  localparam int unsigned NUM_W = 16;
  localparam int unsigned CNT_W = 8;

  // Divisor counts saturate here
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Table builder status as seen by the query control
  typedef struct packed {
    logic busy;  // build in progress, builder owns the count read port
    logic done;  // last table write happens this cycle
  } bld_stat_t;

endpackage

`default_nettype wire

@@ hdl/mdn_ram.sv @@
// ----------------------------------------------------------------------------
// mdn_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read (old data on a same-address write).
// ----------------------------------------------------------------------------
`default_nettype none

module mdn_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ hdl/mdn_build.sv @@
// ----------------------------------------------------------------------------
// mdn_build
// Table builder. Runs a divisor-count sieve as read-modify-write passes over
// the count RAM, then a prefix pass that turns counts into running maxima
// and writes the first holder of each maximum to the holder RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module mdn_build #(
  parameter int unsigned TABLE_SIZE = mdn_pkg::TABLE_SIZE_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output      mdn_pkg::bld_stat_t            stat,
  // count RAM
  output      logic                          cnt_re,
  output      logic [$clog2(TABLE_SIZE)-1:0] cnt_raddr,
  input  wire logic [mdn_pkg::CNT_W-1:0]     cnt_rdata,
  output      logic                          cnt_we,
  output      logic [$clog2(TABLE_SIZE)-1:0] cnt_waddr,
  output      logic [mdn_pkg::CNT_W-1:0]     cnt_wdata,
  // holder RAM (same write address as the count RAM)
  output      logic                          hold_we,
  output      logic [mdn_pkg::NUM_W-1:0]     hold_wdata
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam logic [AW:0]   SIZE_X   = (AW+1)'(TABLE_SIZE);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_SIZE - 1);

  typedef enum logic [3:0] {
    B_IDLE   = 4'b0001,
    B_SIEVE  = 4'b0010,
    B_PREFIX = 4'b0100,
    B_FLUSH  = 4'b1000
  } bstate_t;

  bstate_t state_r, state_nxt;

  // sieve step i and multiple j, one bit wider to catch the end of the table
  logic [AW:0]   i_r, i_nxt;
  logic [AW:0]   j_r, j_nxt;
  logic [AW-1:0] p_r, p_nxt;

  // read-data stage
  logic          b_vld_r;
  logic          b_first_r;
  logic          b_prefix_r;
  logic [AW-1:0] b_addr_r;

  // last count write, for forwarding into a same-address read
  logic                      wr_vld_r;
  logic [AW-1:0]             wr_addr_r;
  logic [mdn_pkg::CNT_W-1:0] wr_data_r;

  // running best of the prefix pass
  logic [mdn_pkg::CNT_W-1:0] best_cnt_r, best_cnt_nxt;
  logic [mdn_pkg::NUM_W-1:0] best_hold_r, best_hold_nxt;

  logic [AW:0]               j_sum;
  logic [AW:0]               i_inc;
  logic                      issue;
  logic [mdn_pkg::CNT_W-1:0] rd_cnt;
  logic                      keep_best;

  assign j_sum = j_r + i_r;
  assign i_inc = i_r + (AW+1)'(1);
  assign issue = (state_r == B_SIEVE) || (state_r == B_PREFIX);

  // issue control and address sequencing
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    p_nxt     = p_r;
    case (state_r)
      B_IDLE: begin
        if (start) begin
          state_nxt = B_SIEVE;
          i_nxt     = (AW+1)'(1);
          j_nxt     = '0;
        end
      end
      B_SIEVE: begin
        if (j_sum >= SIZE_X) begin
          if (i_inc >= SIZE_X) begin
            state_nxt = B_PREFIX;
            p_nxt     = '0;
          end else begin
            i_nxt = i_inc;
            j_nxt = i_inc;
          end
        end else begin
          j_nxt = j_sum;
        end
      end
      B_PREFIX: begin
        if (p_r == LAST_IDX) begin
          state_nxt = B_FLUSH;
        end else begin
          p_nxt = p_r + AW'(1);
        end
      end
      B_FLUSH: begin
        state_nxt = B_IDLE;
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  assign cnt_re    = issue;
  assign cnt_raddr = (state_r == B_PREFIX) ? p_r : j_r[AW-1:0];

  // read data, with the previous cycle's write forwarded
  assign rd_cnt = (wr_vld_r && (wr_addr_r == b_addr_r)) ? wr_data_r : cnt_rdata;
  assign keep_best = (rd_cnt <= best_cnt_r);

  // modify and write back
  always_comb begin
    cnt_wdata     = rd_cnt;
    hold_wdata    = best_hold_r;
    hold_we       = 1'b0;
    best_cnt_nxt  = best_cnt_r;
    best_hold_nxt = best_hold_r;
    if (b_prefix_r) begin
      hold_we = b_vld_r;
      if (keep_best) begin
        cnt_wdata = best_cnt_r;
      end else begin
        hold_wdata = mdn_pkg::NUM_W'(b_addr_r);
        if (b_vld_r) begin
          best_cnt_nxt  = rd_cnt;
          best_hold_nxt = mdn_pkg::NUM_W'(b_addr_r);
        end
      end
    end else if (b_first_r) begin
      // first pass also clears: entry 0 has no divisors, the rest have 1
      cnt_wdata = (b_addr_r == '0) ? '0 : mdn_pkg::CNT_W'(1);
    end else if (rd_cnt != mdn_pkg::CNT_MAX) begin
      cnt_wdata = rd_cnt + mdn_pkg::CNT_W'(1);
    end
  end

  assign cnt_we    = b_vld_r;
  assign cnt_waddr = b_addr_r;

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      b_vld_r  <= 1'b0;
      wr_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      b_vld_r  <= issue;
      wr_vld_r <= b_vld_r;
    end
  end

  // counters and datapath
  always_ff @(posedge clk) begin
    i_r         <= i_nxt;
    j_r         <= j_nxt;
    p_r         <= p_nxt;
    b_first_r   <= (state_r == B_SIEVE) && (i_r == (AW+1)'(1));
    b_prefix_r  <= (state_r == B_PREFIX);
    b_addr_r    <= cnt_raddr;
    wr_addr_r   <= b_addr_r;
    wr_data_r   <= cnt_wdata;
    if (start && (state_r == B_IDLE)) begin
      best_cnt_r  <= '0;
      best_hold_r <= '0;
    end else begin
      best_cnt_r  <= best_cnt_nxt;
      best_hold_r <= best_hold_nxt;
    end
  end

  assign stat.busy = (state_r != B_IDLE);
  assign stat.done = (state_r == B_FLUSH);

  // every write-back follows a read issued in the cycle before
  a_wb_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_we |-> $past(cnt_re))
    else $error("count write without a preceding read");

  // holder writes only come from the prefix pass, after the sieve is over
  a_hold_in_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    hold_we |-> ($past(state_r) == B_PREFIX))
    else $error("holder write outside the prefix pass");

  // the flush cycle always carries the final prefix write
  a_flush_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_FLUSH) |-> (hold_we && (cnt_waddr == LAST_IDX)))
    else $error("flush cycle without the last table write");

endmodule

`default_nettype wire

@@ hdl/most_divisors_up_to_n.sv @@
// ----------------------------------------------------------------------------
// most_divisors_up_to_n
// For a query n, returns the smallest number in 1..n with the most divisors
// and its divisor count, looked up in tables built once after reset.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one query n per transaction (in_tdata[15:0]).
//   out_* : one result per query (best_number, best_divisor_count).
//   After reset the tables are empty. The first query starts a build: a
//   divisor sieve of read-modify-write passes over the count RAM (the
//   first pass also clearing the RAM) and then a prefix pass; no query is
//   taken meanwhile. Reset drops the tables and the next query rebuilds
//   them. Once built, a query is a RAM read and then a load of the output
//   register; a new query is accepted while a result waits. A stalled
//   out_tready holds the result and blocks the next lookup from
//   completing; queries above TABLE_SIZE-1 are answered for TABLE_SIZE-1.
// ----------------------------------------------------------------------------
`default_nettype none

module most_divisors_up_to_n #(
  parameter int unsigned TABLE_SIZE = mdn_pkg::TABLE_SIZE_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] query_value
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata   // [15:0] best_number, [23:16] best_divisor_count
);

  localparam int unsigned AW = $clog2(TABLE_SIZE);
  localparam int unsigned QW = (mdn_pkg::NUM_W > AW) ? mdn_pkg::NUM_W : AW;
  localparam logic [QW-1:0] LAST_Q = QW'(TABLE_SIZE - 1);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_BUILD = 4'b0010,
    ST_ISSUE = 4'b0100,
    ST_DATA  = 4'b1000
  } qstate_t;

  qstate_t state_r, state_nxt;
  logic    built_r, built_nxt;

  logic [mdn_pkg::NUM_W-1:0] n_r;
  logic                      out_tvalid_r, out_tvalid_nxt;
  logic [23:0]               out_tdata_r;

  logic                      in_acc;
  logic                      bld_start;
  mdn_pkg::bld_stat_t        bld_stat;
  logic [mdn_pkg::NUM_W-1:0] q_raw;
  logic [QW-1:0]             q_ext;
  logic [QW-1:0]             q_sat;
  logic [AW-1:0]             q_addr;
  logic                      q_re;
  logic                      out_load;

  // RAM ports
  logic                      bld_re;
  logic [AW-1:0]             bld_raddr;
  logic                      cnt_we;
  logic [AW-1:0]             cnt_waddr;
  logic [mdn_pkg::CNT_W-1:0] cnt_wdata;
  logic                      cnt_re;
  logic [AW-1:0]             cnt_raddr;
  logic [mdn_pkg::CNT_W-1:0] cnt_rdata;
  logic                      hold_we;
  logic [mdn_pkg::NUM_W-1:0] hold_wdata;
  logic [mdn_pkg::NUM_W-1:0] hold_rdata;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign bld_start = in_acc && !built_r;

  // query address, saturated to the last table entry
  assign q_raw  = (state_r == ST_ISSUE) ? n_r : in_tdata;
  assign q_ext  = QW'(q_raw);
  assign q_sat  = (q_ext > LAST_Q) ? LAST_Q : q_ext;
  assign q_addr = q_sat[AW-1:0];
  assign q_re   = (in_acc && built_r) || (state_r == ST_ISSUE);

  assign out_load = (state_r == ST_DATA) && (!out_tvalid_r || out_tready);

  // query sequencing
  always_comb begin
    state_nxt = state_r;
    built_nxt = built_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = built_r ? ST_DATA : ST_BUILD;
        end
      end
      ST_BUILD: begin
        if (bld_stat.done) begin
          state_nxt = ST_ISSUE;
          built_nxt = 1'b1;
        end
      end
      ST_ISSUE: begin
        state_nxt = ST_DATA;
      end
      ST_DATA: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // output register valid
  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      built_r      <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      built_r      <= built_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // query hold and result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      n_r <= in_tdata;
    end
    if (out_load) begin
      out_tdata_r <= {cnt_rdata, hold_rdata};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // table builder
  mdn_build #(
    .TABLE_SIZE (TABLE_SIZE)
  ) u_build (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (bld_start),
    .stat       (bld_stat),
    .cnt_re     (bld_re),
    .cnt_raddr  (bld_raddr),
    .cnt_rdata  (cnt_rdata),
    .cnt_we     (cnt_we),
    .cnt_waddr  (cnt_waddr),
    .cnt_wdata  (cnt_wdata),
    .hold_we    (hold_we),
    .hold_wdata (hold_wdata)
  );

  // count RAM read port: builder while it runs, lookups otherwise
  assign cnt_re    = bld_stat.busy ? bld_re : q_re;
  assign cnt_raddr = bld_stat.busy ? bld_raddr : q_addr;

  mdn_ram #(
    .WIDTH (mdn_pkg::CNT_W),
    .DEPTH (TABLE_SIZE)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  mdn_ram #(
    .WIDTH (mdn_pkg::NUM_W),
    .DEPTH (TABLE_SIZE)
  ) u_hold_ram (
    .clk   (clk),
    .we    (hold_we),
    .waddr (cnt_waddr),
    .wdata (hold_wdata),
    .re    (q_re),
    .raddr (q_addr),
    .rdata (hold_rdata)
  );

  // no lookup read while the builder owns the count RAM
  a_no_lookup_in_build: assert property (@(posedge clk) disable iff (!rst_n)
    bld_stat.busy |-> (!q_re && !in_tready))
    else $error("lookup during table build");

  // a lookup read only happens on built tables
  a_lookup_built: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DATA) |-> built_r)
    else $error("result path entered before tables were built");

  // build completion only follows a running build
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bld_stat.done |-> $past(bld_stat.busy))
    else $error("build done without a running build");

  // result loads always come right after a RAM read or a wait on the output
  a_load_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> ($past(q_re) || ($past(state_r) == ST_DATA)))
    else $error("result loaded without a lookup read");

endmodule

`default_nettype wire

@@ tb/most_divisors_up_to_n_tb.sv @@
// ----------------------------------------------------------------------------
// most_divisors_up_to_n_tb
// Self-checking bench for the most-divisors lookup: drives queries over the
// input stream and checks every answer against tables that the bench builds
// itself (divisor sieve plus running arg-max, ties keep the smaller number).
// Covers query zero, the table and field edges, random queries with random
// idling on both sides, back-to-back traffic and a long output stall that
// backs up the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module most_divisors_up_to_n_tb;

  localparam int unsigned           NUM_W   = mdn_pkg::NUM_W;
  localparam int unsigned           CNT_W   = mdn_pkg::CNT_W;
  localparam logic [CNT_W-1:0]      CNT_MAX = mdn_pkg::CNT_MAX;

  // Full-size table: every 16-bit query lands inside it
  localparam int unsigned TB_TABLE_SIZE = mdn_pkg::TABLE_SIZE_DEF;
  localparam int unsigned MAX_QUERY     = (1 << NUM_W) - 1;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned MAX_PRINTS    = 200;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam longint unsigned TIMEOUT_NS = 64'd10_000_000;

  typedef struct packed {
    logic [NUM_W-1:0] best_num;
    logic [CNT_W-1:0] best_cnt;
  } answer_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;    // [15:0] query_value
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // [15:0] best_number, [23:16] best_divisor_count

  // Bench copy of the lookup tables
  logic [CNT_W-1:0] best_cnt_tbl [TB_TABLE_SIZE];
  logic [NUM_W-1:0] best_num_tbl [TB_TABLE_SIZE];

  answer_t     pending_answers[$];
  int unsigned err_count;
  int unsigned in_idle_max;
  int unsigned out_idle_max;
  int unsigned out_hold_cycles;

  most_divisors_up_to_n #(
    .TABLE_SIZE(TB_TABLE_SIZE)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Divisor sieve, then carry the best count and its first holder forward
  task automatic build_answer_tables();
    int unsigned i;
    int unsigned j;
    for (i = 0; i < TB_TABLE_SIZE; i++) begin
      best_cnt_tbl[i] = '0;
      best_num_tbl[i] = NUM_W'(i);
    end
    for (i = 1; i < TB_TABLE_SIZE; i++) begin
      for (j = i; j < TB_TABLE_SIZE; j += i) begin
        if (best_cnt_tbl[j] != CNT_MAX) best_cnt_tbl[j] = best_cnt_tbl[j] + 1'b1;
      end
    end
    for (i = 2; i < TB_TABLE_SIZE; i++) begin
      if (best_cnt_tbl[i] <= best_cnt_tbl[i-1]) begin
        best_cnt_tbl[i] = best_cnt_tbl[i-1];
        best_num_tbl[i] = best_num_tbl[i-1];
      end
    end
  endtask

  function automatic answer_t lookup_answer(input logic [NUM_W-1:0] n);
    answer_t a;
    int unsigned idx;
    idx = (n > TB_TABLE_SIZE - 1) ? TB_TABLE_SIZE - 1 : int'(n);
    a.best_num = best_num_tbl[idx];
    a.best_cnt = best_cnt_tbl[idx];
    return a;
  endfunction

  // Mix of small, in-table, near-edge and full-range queries
  function automatic logic [NUM_W-1:0] pick_query();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1:    return NUM_W'($urandom_range(0, 64));
      7:       return NUM_W'($urandom_range(TB_TABLE_SIZE - 8, TB_TABLE_SIZE - 1));
      8, 9:    return NUM_W'($urandom_range(0, MAX_QUERY));
      default: return NUM_W'($urandom_range(0, TB_TABLE_SIZE - 1));
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $realtime, msg);
  endtask

  // One query transaction; valid stays high if the next one follows at once
  task automatic send_query(input logic [NUM_W-1:0] n);
    int unsigned gap;
    gap = $urandom_range(0, in_idle_max);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= n;
    do @(posedge clk); while (!in_tready);
    pending_answers = {pending_answers, lookup_answer(n)};
  endtask

  task automatic drop_input();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  // Receiver: random stall before each result, or one long hold on request
  initial begin : result_sink
    int unsigned stall;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (out_hold_cycles > 0) begin
        stall = out_hold_cycles;
        out_hold_cycles = 0;
      end else begin
        stall = $urandom_range(0, out_idle_max);
      end
      @(negedge clk);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Result checker: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    answer_t exp_a;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        exp_a = pending_answers.pop_front();
        if (out_tdata[15:0] !== exp_a.best_num)
          report_mismatch($sformatf("best_number got %0d exp %0d",
                                    out_tdata[15:0], exp_a.best_num));
        if (out_tdata[23:16] !== exp_a.best_cnt)
          report_mismatch($sformatf("best_divisor_count got %0d exp %0d",
                                    out_tdata[23:16], exp_a.best_cnt));
      end
    end
  end

  // Query zero first (it also starts the build), then the field and table edges
  task automatic test_directed_edges();
    logic [NUM_W-1:0] edge_vals[$];
    edge_vals = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6, 16'd11, 16'd12,
                  16'd60, 16'd7560, NUM_W'(TB_TABLE_SIZE - 2), NUM_W'(TB_TABLE_SIZE - 1),
                  NUM_W'(TB_TABLE_SIZE), NUM_W'(TB_TABLE_SIZE + 1), 16'h5555, 16'hAAAA,
                  16'h8000, 16'hFFFE, 16'hFFFF, 16'd0};
    foreach (edge_vals[k]) send_query(edge_vals[k]);
  endtask

  task automatic test_random_queries(input int unsigned n_items);
    in_idle_max  = 15;
    out_idle_max = 15;
    repeat (n_items) send_query(pick_query());
  endtask

  // No idling on either side
  task automatic test_back_to_back(input int unsigned n_items);
    in_idle_max  = 0;
    out_idle_max = 0;
    repeat (n_items) send_query(pick_query());
  endtask

  // Long output hold while queries keep coming, so the input must stall
  task automatic test_output_stall(input int unsigned n_items);
    in_idle_max     = 0;
    out_idle_max    = 3;
    out_hold_cycles = HOLD_CYCLES;
    repeat (n_items) send_query(pick_query());
  endtask

  // Timeout
  initial begin
    #(TIMEOUT_NS);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    err_count       = 0;
    in_idle_max     = 15;
    out_idle_max    = 15;
    out_hold_cycles = 0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    rst_n           = 1'b0;
    build_answer_tables();
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    test_directed_edges();
    test_random_queries(950);
    test_back_to_back(200);
    test_output_stall(60);
    test_random_queries(30);
    drop_input();

    // Drain, then keep watching the output for any stray result
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/mdn_pkg.sv
hdl/mdn_ram.sv
hdl/mdn_build.sv
hdl/most_divisors_up_to_n.sv
tb/most_divisors_up_to_n_tb.sv
